>>> hdl/page_framebuffer_blitter_unit_assert.svh
// assertion macros shared by the framebuffer blitter modules
`ifndef PAGE_FRAMEBUFFER_BLITTER_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_BLITTER_UNIT_ASSERT_SVH

// condition must hold on every clock edge outside reset
`define PFB_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pfb assertion failed");

// consequence must hold in the same cycle as the antecedent
`define PFB_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfb assertion failed");

// consequence must hold in the cycle after the antecedent
`define PFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfb assertion failed");

`endif

>>> hdl/pfb_pkg.sv
// types and constants of the page framebuffer blitter
`default_nettype none

package pfb_pkg;

  localparam int PFB_SCREEN_COLUMNS = 128;
  localparam int PFB_SCREEN_ROWS    = 64;
  localparam int PFB_STORE_BYTES    = 1024;
  localparam int PFB_STORE_AW       = 10;

  localparam logic [7:0] PFB_WIDTH_RESET  = 8'd128;
  localparam logic [7:0] PFB_HEIGHT_RESET = 8'd64;

  // command codes
  localparam logic [2:0] MODE_BLIT  = 3'd0;
  localparam logic [2:0] MODE_PIXEL = 3'd1;
  localparam logic [2:0] MODE_LINE  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // register index on the config port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] bitmap_byte;
    logic       start_bitmap;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
    logic [7:0] line_start;
    logic [7:0] line_length;
    logic [9:0] read_address;
  } pfb_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bitmap_done;
    logic       bitmap_overrun;
  } pfb_rsp_t;

  typedef enum logic [1:0] {
    ENG_WALK,
    ENG_CLEAR,
    ENG_READ
  } pfb_op_t;

  // a run of pixels on one screen row, one pixel per step
  typedef struct packed {
    logic [7:0] x0;
    logic [7:0] y;
    logic [7:0] count;
    logic [7:0] bits;
    logic       clip_en;
    logic [8:0] col0;
    logic [8:0] col_limit;
  } pfb_walk_t;

  typedef struct packed {
    logic                    go;
    pfb_op_t                 op;
    pfb_walk_t               walk;
    logic [PFB_STORE_AW-1:0] read_addr;
  } pfb_eng_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] rdata;
  } pfb_eng_sts_t;

endpackage

`default_nettype wire

>>> hdl/pfb_engine.sv
// frame store with read-modify-write pixel engine, clear sweep and byte read
`default_nettype none
`include "page_framebuffer_blitter_unit_assert.svh"

module pfb_engine import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = PFB_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = PFB_SCREEN_ROWS
) (
  input  logic         clk,
  input  logic         rst,
  input  pfb_eng_req_t req,
  output pfb_eng_sts_t sts
);

  localparam int ADDR_W = 14;
  localparam logic [8:0]        COLS      = 9'(SCREEN_COLUMNS);
  localparam logic [8:0]        ROWS      = 9'(SCREEN_ROWS);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] STORE_LIM = ADDR_W'(PFB_STORE_BYTES);

  typedef enum logic [1:0] {
    E_SWEEP,
    E_IDLE,
    E_WALK,
    E_READ
  } eng_state_t;

  eng_state_t state;

  logic [PFB_STORE_AW-1:0] sweep_addr;
  logic                    sweep_cmd;
  logic                    done;
  logic [7:0]              rdata;

  logic [7:0] walk_x;
  logic [7:0] walk_y;
  logic [7:0] walk_left;
  logic [7:0] walk_bits;
  logic       walk_clip;
  logic [8:0] walk_col;
  logic [8:0] walk_lim;

  logic                    s1_valid;
  logic [PFB_STORE_AW-1:0] s1_addr;
  logic [7:0]              s1_mask;
  logic                    s1_on;

  logic [7:0] frame_mem [PFB_STORE_BYTES];
  logic [7:0] rd_q;

  logic                    step_fire;
  logic                    col_ok;
  logic                    in_screen;
  logic                    addr_ok;
  logic [ADDR_W-1:0]       pix_addr;
  logic [PFB_STORE_AW-1:0] rd_addr;
  logic                    we;
  logic [PFB_STORE_AW-1:0] waddr;
  logic [7:0]              wdata;

  always_comb begin
    step_fire = (state == E_WALK) && (walk_left != 8'd0);
    col_ok    = !walk_clip || (walk_col < walk_lim);
    in_screen = ({1'b0, walk_x} < COLS) && ({1'b0, walk_y} < ROWS);
    // page layout: one byte per column, eight rows per page
    pix_addr  = ADDR_W'(walk_x) + ADDR_W'(walk_y[7:3]) * COLS_A;
    addr_ok   = pix_addr < STORE_LIM;
    rd_addr   = (state == E_IDLE) ? req.read_addr : pix_addr[PFB_STORE_AW-1:0];
    if (state == E_SWEEP) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = 8'd0;
    end else begin
      we    = s1_valid;
      waddr = s1_addr;
      wdata = s1_on ? (rd_q | s1_mask) : (rd_q & ~s1_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      frame_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= frame_mem[rd_addr];
  end

  // walk payload and the pixel write stage
  always_ff @(posedge clk) begin
    s1_addr <= pix_addr[PFB_STORE_AW-1:0];
    s1_mask <= 8'd1 << walk_y[2:0];
    s1_on   <= walk_bits[7];
    if (state == E_IDLE && req.go && req.op == ENG_WALK) begin
      walk_x    <= req.walk.x0;
      walk_y    <= req.walk.y;
      walk_left <= req.walk.count;
      walk_bits <= req.walk.bits;
      walk_clip <= req.walk.clip_en;
      walk_col  <= req.walk.col0;
      walk_lim  <= req.walk.col_limit;
    end else if (step_fire) begin
      walk_x    <= walk_x + 8'd1;
      walk_left <= walk_left - 8'd1;
      walk_bits <= {walk_bits[6:0], walk_bits[0]};
      walk_col  <= walk_col + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= E_SWEEP;
      sweep_addr <= '0;
      sweep_cmd  <= 1'b0;
      s1_valid   <= 1'b0;
      done       <= 1'b0;
      rdata      <= 8'd0;
    end else begin
      done     <= 1'b0;
      s1_valid <= step_fire && col_ok && in_screen && addr_ok;
      case (state)
        E_SWEEP: begin
          sweep_addr <= sweep_addr + PFB_STORE_AW'(1);
          if (sweep_addr == '1) begin
            state     <= E_IDLE;
            sweep_cmd <= 1'b0;
            // the sweep after reset reports nothing
            if (sweep_cmd) begin
              done  <= 1'b1;
              rdata <= 8'd0;
            end
          end
        end
        E_IDLE: begin
          if (req.go) begin
            case (req.op)
              ENG_WALK: begin
                state <= E_WALK;
              end
              ENG_CLEAR: begin
                sweep_addr <= '0;
                sweep_cmd  <= 1'b1;
                state      <= E_SWEEP;
              end
              ENG_READ: begin
                state <= E_READ;
              end
              default: begin
                state <= E_IDLE;
              end
            endcase
          end
        end
        E_WALK: begin
          // last pixel write lands on the edge that leaves this state
          if (!step_fire) begin
            done  <= 1'b1;
            rdata <= 8'd0;
            state <= E_IDLE;
          end
        end
        E_READ: begin
          done  <= 1'b1;
          rdata <= rd_q;
          state <= E_IDLE;
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign sts.busy  = (state != E_IDLE);
  assign sts.done  = done;
  assign sts.rdata = rdata;

  `PFB_ASSERT_IMPLIES(a_write_in_walk, s1_valid, state == E_WALK)
  `PFB_ASSERT_NEXT(a_done_single, done, !done)
  `PFB_ASSERT_IMPLIES(a_done_idle, done, state == E_IDLE)

endmodule

`default_nettype wire

>>> hdl/page_framebuffer_blitter_unit.sv
// top level of the page framebuffer blitter: config port, command decode, result register
`default_nettype none
`include "page_framebuffer_blitter_unit_assert.svh"

// Keeps a monochrome screen in a 1024-byte frame store (page layout, one byte per column
// holding eight rows) and takes one request at a time: blit one source byte, set or clear a
// pixel, draw a horizontal run, clear the store, or read one byte back. Every request gives
// exactly one response through a register, so a new request can be taken while the last
// response waits. The frame store has one write and one read port and every pixel is a
// read-modify-write of one byte, one pixel per cycle. After reset the store is zeroed by a
// sweep, one byte a cycle, during which requests stall; config writes are taken at any
// time. bitmap_width is at byte address 0 and bitmap_height at 4.
module page_framebuffer_blitter_unit import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = PFB_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = PFB_SCREEN_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  pfb_cmd_t    cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output pfb_rsp_t    rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_WAIT,
    T_HOLD
  } top_state_t;

  top_state_t state;

  logic [7:0] bitmap_width;
  logic [7:0] bitmap_height;
  logic [7:0] cursor_row;
  logic [5:0] cursor_byte_column;
  logic [7:0] blit_origin_x;
  logic [7:0] blit_origin_y;
  logic       blit_active;
  pfb_rsp_t   res;

  logic [7:0] cursor_row_next;
  logic [5:0] cursor_byte_column_next;
  logic [7:0] blit_origin_x_next;
  logic [7:0] blit_origin_y_next;
  logic       blit_active_next;

  logic         accept;
  logic         needs_engine;
  logic         done_flag;
  logic         overrun_flag;
  logic         eff_active;
  logic [7:0]   eff_row;
  logic [5:0]   eff_col;
  logic [5:0]   col_inc;
  logic [7:0]   row_inc;
  logic [5:0]   row_bytes;
  pfb_eng_req_t eng_req;
  pfb_eng_sts_t eng_sts;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {24'd0, bitmap_height} : {24'd0, bitmap_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_width  <= PFB_WIDTH_RESET;
      bitmap_height <= PFB_HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEIGHT) begin
        bitmap_height <= pwdata[7:0];
      end else begin
        bitmap_width <= pwdata[7:0];
      end
    end
  end

  assign cmd_stall = (state != T_IDLE) || eng_sts.busy;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    eng_req      = '0;
    needs_engine = 1'b0;
    done_flag    = 1'b0;
    overrun_flag = 1'b0;

    eff_active = cmd.start_bitmap ? ((bitmap_width != 8'd0) && (bitmap_height != 8'd0))
                                  : blit_active;
    eff_row    = cmd.start_bitmap ? 8'd0 : cursor_row;
    eff_col    = cmd.start_bitmap ? 6'd0 : cursor_byte_column;
    col_inc    = eff_col + 6'd1;
    row_inc    = eff_row + 8'd1;
    row_bytes  = 6'(({1'b0, bitmap_width} + 9'd7) >> 3);

    cursor_row_next         = cursor_row;
    cursor_byte_column_next = cursor_byte_column;
    blit_origin_x_next      = blit_origin_x;
    blit_origin_y_next      = blit_origin_y;
    blit_active_next        = blit_active;

    case (cmd.mode)
      MODE_BLIT: begin
        if (cmd.start_bitmap) begin
          blit_origin_x_next = cmd.pixel_x;
          blit_origin_y_next = cmd.pixel_y;
        end
        cursor_row_next         = eff_row;
        cursor_byte_column_next = eff_col;
        blit_active_next        = eff_active;
        if (eff_active) begin
          needs_engine           = 1'b1;
          eng_req.op             = ENG_WALK;
          eng_req.walk.x0        = blit_origin_x_next + {eff_col[4:0], 3'b000};
          eng_req.walk.y         = blit_origin_y_next + eff_row;
          eng_req.walk.count     = 8'd8;
          eng_req.walk.bits      = cmd.bitmap_byte;
          eng_req.walk.clip_en   = 1'b1;
          eng_req.walk.col0      = {eff_col, 3'b000};
          eng_req.walk.col_limit = {1'b0, bitmap_width};
          // row ends once the byte column reaches the row length
          if (col_inc >= row_bytes) begin
            cursor_byte_column_next = 6'd0;
            cursor_row_next         = row_inc;
            if (row_inc == 8'd0 || row_inc >= bitmap_height) begin
              blit_active_next = 1'b0;
              done_flag        = 1'b1;
            end
          end else begin
            cursor_byte_column_next = col_inc;
          end
        end else begin
          overrun_flag = 1'b1;
        end
      end
      MODE_PIXEL: begin
        needs_engine       = 1'b1;
        eng_req.op         = ENG_WALK;
        eng_req.walk.x0    = cmd.pixel_x;
        eng_req.walk.y     = cmd.pixel_y;
        eng_req.walk.count = 8'd1;
        eng_req.walk.bits  = {8{cmd.pixel_on}};
      end
      MODE_LINE: begin
        needs_engine       = 1'b1;
        eng_req.op         = ENG_WALK;
        eng_req.walk.x0    = cmd.line_start;
        eng_req.walk.y     = cmd.pixel_y;
        eng_req.walk.count = cmd.line_length;
        eng_req.walk.bits  = 8'hFF;
      end
      MODE_CLEAR: begin
        needs_engine = 1'b1;
        eng_req.op   = ENG_CLEAR;
      end
      MODE_READ: begin
        needs_engine = 1'b1;
        eng_req.op   = ENG_READ;
      end
      default: begin
        needs_engine = 1'b0;
      end
    endcase

    eng_req.go        = accept && needs_engine;
    eng_req.read_addr = cmd.read_address;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= T_IDLE;
      cursor_row         <= 8'd0;
      cursor_byte_column <= 6'd0;
      blit_origin_x      <= 8'd0;
      blit_origin_y      <= 8'd0;
      blit_active        <= 1'b0;
      rsp_valid          <= 1'b0;
    end else begin
      // response register free or emptying this cycle
      if (state == T_HOLD && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            cursor_row             <= cursor_row_next;
            cursor_byte_column     <= cursor_byte_column_next;
            blit_origin_x          <= blit_origin_x_next;
            blit_origin_y          <= blit_origin_y_next;
            blit_active            <= blit_active_next;
            res.read_data          <= 8'd0;
            res.bitmap_done        <= done_flag;
            res.bitmap_overrun     <= overrun_flag;
            state                  <= needs_engine ? T_WAIT : T_HOLD;
          end
        end
        T_WAIT: begin
          if (eng_sts.done) begin
            res.read_data <= eng_sts.rdata;
            state         <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  pfb_engine #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .req(eng_req),
    .sts(eng_sts)
  );

  `PFB_ASSERT_IMPLIES(a_done_while_waiting, eng_sts.done, state == T_WAIT)
  `PFB_ASSERT_NEXT(a_one_request_at_a_time, accept, cmd_stall)
  `PFB_ASSERT_ALWAYS(a_flags_exclusive, !(rsp_valid && rsp.bitmap_done && rsp.bitmap_overrun))

endmodule

`default_nettype wire
